// ===== hw/rtl/char_lcd_shadow_refresh_core_macros.svh =====
// assertion macros for char_lcd_shadow_refresh_core.sv, the only file that checks itself
`ifndef CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH
`define CHAR_LCD_SHADOW_REFRESH_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CLSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clsr check failed");

// next-cycle implication, clocked on clk, off during reset
`define CLSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clsr check failed");

`endif

// ===== hw/rtl/clsr_pkg.sv =====
package clsr_pkg;

  localparam int MAX_ROWS = 4;
  localparam int MAX_COLS = 20;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = 2;
  localparam int COL_W    = 5;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int ADDR_W   = 7;
  localparam int CHAR_W   = 8;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  // host opcodes
  localparam logic [2:0] OPC_WRITE_CHAR = 3'd0;
  localparam logic [2:0] OPC_SET_CURSOR = 3'd1;
  localparam logic [2:0] OPC_REPORT     = 3'd2;
  localparam logic [2:0] OPC_CLEAR      = 3'd3;
  localparam logic [2:0] OPC_REFRESH    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_SET_ADDR   = 2'd0;
  localparam logic [1:0] KIND_WRITE_DATA = 2'd1;
  localparam logic [1:0] KIND_CLEAR      = 2'd2;
  localparam logic [1:0] KIND_CURSOR     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_OFFSET = 3'd5;

  localparam logic [2:0]        RST_ACTIVE_ROWS = 3'd4;
  localparam logic [4:0]        RST_ACTIVE_COLS = 5'd20;
  localparam logic [ADDR_W-1:0] RST_ROW0_OFFSET = 7'h00;
  localparam logic [ADDR_W-1:0] RST_ROW1_OFFSET = 7'h40;
  localparam logic [ADDR_W-1:0] RST_ROW2_OFFSET = 7'h14;
  localparam logic [ADDR_W-1:0] RST_ROW3_OFFSET = 7'h54;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [2:0]        row;
    logic [4:0]        col;
    logic [CHAR_W-1:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        cmd_kind;
    logic [ADDR_W-1:0] address;
    logic [CHAR_W-1:0] data;
    logic [1:0]        pos_row;
    logic [4:0]        pos_col;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_SET_CURSOR,
    CMD_REPORT,
    CMD_CLEAR,
    CMD_REFRESH
  } op_e;

  // classified command held in the queue
  typedef struct packed {
    op_e               op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic              last_row;
  } cmd_t;

  typedef struct packed {
    logic [MAX_COLS-1:0]              col_mask;
    logic [MAX_ROWS-1:0][ADDR_W-1:0]  offset;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WCMP,
    BK_SCAN,
    BK_FINISH
  } back_state_e;

  function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    cell_index = CELL_W'(int'(row) * MAX_COLS + int'(col));
  endfunction

endpackage

// ===== hw/rtl/char_lcd_shadow_refresh_core.sv =====
// Shadow store of a 4x20 character display with a dirty bit per cell. A command word is
// taken at a clock edge where start is high and busy is low; busy rises only while the
// two-entry command queue is full. The executing side handles one command at a time:
// write char reads the store, then compares and writes; set cursor, report and clear
// are handled in the idle state; a row refresh scans each column from 0 up to the
// highest dirty cell in the active columns and then finishes, paced by the single read
// port of the character store, one column a cycle. Each result word is on result for
// exactly one cycle with strobe high; it is staged in pend and then registered;
// there is no backpressure, so the consumer must take every word as it comes. Cells
// carry valid bits, so reset and clear take effect at once with no sweep. Write the
// configuration registers only while idle.
`include "char_lcd_shadow_refresh_core_macros.svh"

module char_lcd_shadow_refresh_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  clsr_pkg::in_word_t               cmd,
  output logic                             strobe,
  output clsr_pkg::out_word_t              result,
  input  logic                             cfg_we,
  input  logic [clsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clsr_pkg::CFG_W-1:0]       cfg_data
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  clsr_pkg::cmd_t  q_in;
  clsr_pkg::cmd_t  q_out;
  clsr_pkg::cfg_t  cfg;

  clsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (q_push),
    .push_word (q_in),
    .cfg       (cfg)
  );

  clsr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  clsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_out),
    .cfg     (cfg),
    .q_pop   (q_pop),
    .strobe  (strobe),
    .result  (result)
  );

  `CLSR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid)
  `CLSR_ASSERT_IMPL(a_push_room, q_push, !q_full)
  `CLSR_ASSERT_IMPL(a_single_is_last, strobe && (result.cmd_kind != clsr_pkg::KIND_WRITE_DATA), result.last)
  `CLSR_ASSERT_NEXT(a_full_holds, q_full && !q_pop, busy)

endmodule

// ===== hw/rtl/clsr_ram.sv =====
module clsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/clsr_queue.sv =====
module clsr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clsr_pkg::cmd_t    din,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output clsr_pkg::cmd_t    dout
);

  clsr_pkg::cmd_t                   mem [clsr_pkg::QDEPTH];
  logic [clsr_pkg::QPTR_W-1:0]      wr_ptr;
  logic [clsr_pkg::QPTR_W-1:0]      rd_ptr;
  logic [clsr_pkg::QCNT_W-1:0]      count;

  assign full  = (count == clsr_pkg::QCNT_W'(clsr_pkg::QDEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == clsr_pkg::QPTR_W'(clsr_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == clsr_pkg::QPTR_W'(clsr_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/clsr_front.sv =====
module clsr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  clsr_pkg::in_word_t                cmd,
  input  logic                              cfg_we,
  input  logic [clsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clsr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              q_full,
  output logic                              busy,
  output logic                              push,
  output clsr_pkg::cmd_t                    push_word,
  output clsr_pkg::cfg_t                    cfg
);

  logic [2:0]                                      active_rows;
  logic [4:0]                                      active_cols;
  logic [clsr_pkg::MAX_ROWS-1:0][clsr_pkg::ADDR_W-1:0] row_off;
  logic [2:0]                                      rows_eff;
  logic [4:0]                                      cols_eff;
  logic                                            in_grid;
  logic                                            item_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= clsr_pkg::RST_ACTIVE_ROWS;
      active_cols <= clsr_pkg::RST_ACTIVE_COLS;
      row_off[0]  <= clsr_pkg::RST_ROW0_OFFSET;
      row_off[1]  <= clsr_pkg::RST_ROW1_OFFSET;
      row_off[2]  <= clsr_pkg::RST_ROW2_OFFSET;
      row_off[3]  <= clsr_pkg::RST_ROW3_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        clsr_pkg::REG_ACTIVE_ROWS: active_rows <= cfg_data[2:0];
        clsr_pkg::REG_ACTIVE_COLS: active_cols <= cfg_data[4:0];
        clsr_pkg::REG_ROW0_OFFSET: row_off[0]  <= cfg_data;
        clsr_pkg::REG_ROW1_OFFSET: row_off[1]  <= cfg_data;
        clsr_pkg::REG_ROW2_OFFSET: row_off[2]  <= cfg_data;
        clsr_pkg::REG_ROW3_OFFSET: row_off[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // register values above the display size are clamped
  always_comb begin
    rows_eff = (active_rows > 3'(clsr_pkg::MAX_ROWS)) ? 3'(clsr_pkg::MAX_ROWS) : active_rows;
    cols_eff = (active_cols > 5'(clsr_pkg::MAX_COLS)) ? 5'(clsr_pkg::MAX_COLS) : active_cols;
    for (int i = 0; i < clsr_pkg::MAX_COLS; i++) begin
      cfg.col_mask[i] = (5'(i) < cols_eff);
    end
    cfg.offset = row_off;
  end

  always_comb begin
    in_grid = (cmd.row < 3'(clsr_pkg::MAX_ROWS)) && (cmd.col < 5'(clsr_pkg::MAX_COLS));
    push_word.row      = cmd.row[clsr_pkg::ROW_W-1:0];
    push_word.col      = cmd.col;
    push_word.ch       = cmd.char_code;
    push_word.last_row = (cmd.row == rows_eff - 3'd1);
    case (cmd.opcode)
      clsr_pkg::OPC_WRITE_CHAR: begin
        push_word.op = clsr_pkg::CMD_WRITE;
        item_ok      = in_grid;
      end
      clsr_pkg::OPC_SET_CURSOR: begin
        push_word.op = clsr_pkg::CMD_SET_CURSOR;
        item_ok      = in_grid;
      end
      clsr_pkg::OPC_REPORT: begin
        push_word.op = clsr_pkg::CMD_REPORT;
        item_ok      = 1'b1;
      end
      clsr_pkg::OPC_CLEAR: begin
        push_word.op = clsr_pkg::CMD_CLEAR;
        item_ok      = 1'b1;
      end
      clsr_pkg::OPC_REFRESH: begin
        // inactive rows are dropped here
        push_word.op = clsr_pkg::CMD_REFRESH;
        item_ok      = (cmd.row < rows_eff);
      end
      default: begin
        push_word.op = clsr_pkg::CMD_REPORT;
        item_ok      = 1'b0;
      end
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full && item_ok;

endmodule

// ===== hw/rtl/clsr_back.sv =====
module clsr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  clsr_pkg::cmd_t       q_word,
  input  clsr_pkg::cfg_t       cfg,
  output logic                 q_pop,
  output logic                 strobe,
  output clsr_pkg::out_word_t  result
);

  clsr_pkg::back_state_e state, state_next;

  logic [clsr_pkg::CELLS-1:0]                          cell_vld;
  logic [clsr_pkg::MAX_ROWS-1:0][clsr_pkg::MAX_COLS-1:0] dirty;
  logic [clsr_pkg::ROW_W-1:0]                          cur_row;
  logic [clsr_pkg::COL_W-1:0]                          cur_col;
  logic                                                changed;

  logic [clsr_pkg::CELL_W-1:0]  wr_idx;
  logic [clsr_pkg::ROW_W-1:0]   wr_row;
  logic [clsr_pkg::COL_W-1:0]   wr_col;
  logic [clsr_pkg::CHAR_W-1:0]  wr_ch;
  logic                         wr_seen;

  logic [clsr_pkg::ROW_W-1:0]   ref_row;
  logic                         ref_last;
  logic [clsr_pkg::MAX_COLS-1:0] scan;
  logic [clsr_pkg::COL_W-1:0]   scan_col;

  clsr_pkg::out_word_t          pend;
  clsr_pkg::out_word_t          pend_out;
  logic                         pend_vld;
  logic                         pend_vld_next;
  logic                         pend_ram;
  logic                         pend_seen;

  logic [clsr_pkg::CELL_W-1:0]  q_idx;
  logic [clsr_pkg::CELL_W-1:0]  scan_idx;
  logic [clsr_pkg::CELL_W-1:0]  rd_addr;
  logic [clsr_pkg::CHAR_W-1:0]  rd_data;
  logic [clsr_pkg::CHAR_W-1:0]  stored;
  logic                         ram_we;
  logic [clsr_pkg::MAX_COLS-1:0] scan_rest;
  logic [clsr_pkg::MAX_COLS-1:0] row_dirty;
  logic [clsr_pkg::ADDR_W-1:0]  q_addr;
  logic [clsr_pkg::ADDR_W-1:0]  scan_addr;
  logic [clsr_pkg::ADDR_W-1:0]  cur_addr;

  clsr_ram #(
    .WIDTH (clsr_pkg::CHAR_W),
    .DEPTH (clsr_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_ch),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    q_idx     = clsr_pkg::cell_index(q_word.row, q_word.col);
    scan_idx  = clsr_pkg::cell_index(ref_row, scan_col);
    rd_addr   = (state == clsr_pkg::BK_SCAN) ? scan_idx : q_idx;
    // a cell never written since reset or clear holds a space
    stored    = wr_seen ? rd_data : clsr_pkg::SPACE_CHAR;
    ram_we    = (state == clsr_pkg::BK_WCMP) && (stored != wr_ch);
    scan_rest = scan & ~(clsr_pkg::MAX_COLS'(1) << scan_col);
    row_dirty = dirty[q_word.row] & cfg.col_mask;
    q_addr    = cfg.offset[q_word.row] + clsr_pkg::ADDR_W'(q_word.col);
    scan_addr = cfg.offset[ref_row] + clsr_pkg::ADDR_W'(scan_col);
    cur_addr  = cfg.offset[cur_row] + clsr_pkg::ADDR_W'(cur_col);
    pend_out      = pend;
    pend_out.data = pend_ram ? (pend_seen ? rd_data : clsr_pkg::SPACE_CHAR) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clsr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      clsr_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_word.op)
            clsr_pkg::CMD_WRITE:   state_next = clsr_pkg::BK_WCMP;
            clsr_pkg::CMD_REFRESH: state_next = (row_dirty != '0) ? clsr_pkg::BK_SCAN
                                                                  : clsr_pkg::BK_FINISH;
            default:               state_next = clsr_pkg::BK_IDLE;
          endcase
        end
      end
      clsr_pkg::BK_WCMP:   state_next = clsr_pkg::BK_IDLE;
      clsr_pkg::BK_SCAN:   state_next = (scan_rest == '0) ? clsr_pkg::BK_FINISH
                                                          : clsr_pkg::BK_SCAN;
      clsr_pkg::BK_FINISH: state_next = clsr_pkg::BK_IDLE;
      default:             state_next = clsr_pkg::BK_IDLE;
    endcase
  end

  // a result word is staged in pend this cycle
  always_comb begin
    case (state)
      clsr_pkg::BK_IDLE:   pend_vld_next = q_valid &&
                             (q_word.op inside {clsr_pkg::CMD_SET_CURSOR, clsr_pkg::CMD_REPORT,
                                                clsr_pkg::CMD_CLEAR});
      clsr_pkg::BK_SCAN:   pend_vld_next = scan[scan_col];
      clsr_pkg::BK_FINISH: pend_vld_next = ref_last && changed;
      default:             pend_vld_next = 1'b0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= pend_out;
    case (state)
      clsr_pkg::BK_IDLE: begin
        if (q_valid) begin
          wr_idx    <= q_idx;
          wr_row    <= q_word.row;
          wr_col    <= q_word.col;
          wr_ch     <= q_word.ch;
          wr_seen   <= cell_vld[q_idx];
          ref_row   <= q_word.row;
          ref_last  <= q_word.last_row;
          scan      <= row_dirty;
          scan_col  <= '0;
          pend_ram  <= 1'b0;
          case (q_word.op)
            clsr_pkg::CMD_SET_CURSOR:
              pend <= '{clsr_pkg::KIND_SET_ADDR, q_addr, '0, '0, '0, 1'b1};
            clsr_pkg::CMD_REPORT:
              pend <= '{clsr_pkg::KIND_CURSOR, '0, '0, cur_row, cur_col, 1'b1};
            clsr_pkg::CMD_CLEAR:
              pend <= '{clsr_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b1};
            default: ;
          endcase
        end
      end
      clsr_pkg::BK_SCAN: begin
        if (scan[scan_col]) begin
          // the cursor word follows on the last active row
          pend      <= '{clsr_pkg::KIND_WRITE_DATA, scan_addr, '0, '0, '0,
                         (scan_rest == '0) && !ref_last};
          pend_ram  <= 1'b1;
          pend_seen <= cell_vld[scan_idx];
        end
        scan     <= scan_rest;
        scan_col <= scan_col + 1'b1;
      end
      clsr_pkg::BK_FINISH: begin
        pend     <= '{clsr_pkg::KIND_SET_ADDR, cur_addr, '0, '0, '0, 1'b1};
        pend_ram <= 1'b0;
      end
      default: ;
    endcase
  end

  // control and shadow state
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld <= '0;
      dirty    <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      changed  <= 1'b0;
      pend_vld <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe   <= pend_vld;
      pend_vld <= pend_vld_next;
      case (state)
        clsr_pkg::BK_IDLE: begin
          if (q_valid) begin
            case (q_word.op)
              clsr_pkg::CMD_SET_CURSOR: begin
                cur_row  <= q_word.row;
                cur_col  <= q_word.col;
              end
              clsr_pkg::CMD_CLEAR: begin
                cell_vld <= '0;
                dirty    <= '0;
              end
              clsr_pkg::CMD_REFRESH: dirty[q_word.row] <= '0;
              default: ;
            endcase
          end
        end
        clsr_pkg::BK_WCMP: begin
          if (ram_we) begin
            cell_vld[wr_idx]      <= 1'b1;
            dirty[wr_row][wr_col] <= 1'b1;
          end
        end
        clsr_pkg::BK_SCAN: begin
          if (scan[scan_col]) begin
            changed  <= 1'b1;
          end
        end
        clsr_pkg::BK_FINISH: begin
          if (ref_last) begin
            changed  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned NUM_PHASES    = 6;

  // opcodes with no function
  localparam logic [2:0] OPC_RSVD5 = 3'd5;
  localparam logic [2:0] OPC_RSVD6 = 3'd6;
  localparam logic [2:0] OPC_RSVD7 = 3'd7;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  clsr_pkg::in_word_t             cmd;
  logic                           strobe;
  clsr_pkg::out_word_t            result;
  logic                           cfg_we;
  logic [clsr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [clsr_pkg::CFG_W-1:0]     cfg_data;

  char_lcd_shadow_refresh_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    clsr_pkg::in_word_t  word;
    bit                  typed;
    int                  n_want;
    clsr_pkg::out_word_t want;
  } directed_row_t;

  // shadow of the display as the block should hold it
  logic [clsr_pkg::CHAR_W-1:0]   shadow_chars [clsr_pkg::MAX_ROWS][clsr_pkg::MAX_COLS];
  logic [clsr_pkg::MAX_COLS-1:0] dirty_cols [clsr_pkg::MAX_ROWS];
  logic [clsr_pkg::ROW_W-1:0]    cur_r;
  logic [clsr_pkg::COL_W-1:0]    cur_c;
  logic                          rewrite_cursor;
  logic [2:0]                    rows_reg;
  logic [4:0]                    cols_reg;
  logic [clsr_pkg::ADDR_W-1:0]   row_base [clsr_pkg::MAX_ROWS];

  clsr_pkg::out_word_t step_words [$];
  clsr_pkg::out_word_t lcd_cmds_due [$];
  directed_row_t       directed_rows [$];

  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic clsr_pkg::in_word_t mk_word(logic [2:0] op, logic [2:0] r,
                                                 logic [4:0] c, logic [7:0] ch);
    clsr_pkg::in_word_t w;
    w.opcode    = op;
    w.row       = r;
    w.col       = c;
    w.char_code = ch;
    return w;
  endfunction

  function automatic clsr_pkg::out_word_t mk_result(logic [1:0] kind,
                                                    logic [clsr_pkg::ADDR_W-1:0] addr,
                                                    logic [7:0] data, logic [1:0] crow,
                                                    logic [4:0] ccol, logic lst);
    clsr_pkg::out_word_t o;
    o.cmd_kind = kind;
    o.address  = addr;
    o.data     = data;
    o.pos_row  = crow;
    o.pos_col  = ccol;
    o.last     = lst;
    return o;
  endfunction

  function automatic logic [clsr_pkg::ADDR_W-1:0] cell_addr(int r, int c);
    return clsr_pkg::ADDR_W'(int'(row_base[r]) + c);
  endfunction

  task automatic lcd_reset_state();
    for (int r = 0; r < clsr_pkg::MAX_ROWS; r++) begin
      dirty_cols[r] = '0;
      for (int c = 0; c < clsr_pkg::MAX_COLS; c++) shadow_chars[r][c] = clsr_pkg::SPACE_CHAR;
    end
    cur_r          = '0;
    cur_c          = '0;
    rewrite_cursor = 1'b0;
    rows_reg       = clsr_pkg::RST_ACTIVE_ROWS;
    cols_reg       = clsr_pkg::RST_ACTIVE_COLS;
    row_base[0]    = clsr_pkg::RST_ROW0_OFFSET;
    row_base[1]    = clsr_pkg::RST_ROW1_OFFSET;
    row_base[2]    = clsr_pkg::RST_ROW2_OFFSET;
    row_base[3]    = clsr_pkg::RST_ROW3_OFFSET;
  endtask

  // display commands caused by one host word, left in step_words
  task automatic predict_lcd_cmds(input clsr_pkg::in_word_t w);
    int                  r;
    int                  c;
    int                  rows_eff;
    int                  cols_eff;
    clsr_pkg::out_word_t tail;
    r = w.row;
    c = w.col;
    step_words.delete();
    case (w.opcode)
      clsr_pkg::OPC_WRITE_CHAR: begin
        if (r < clsr_pkg::MAX_ROWS && c < clsr_pkg::MAX_COLS &&
            shadow_chars[r][c] != w.char_code) begin
          shadow_chars[r][c] = w.char_code;
          dirty_cols[r][c]   = 1'b1;
        end
      end
      clsr_pkg::OPC_SET_CURSOR: begin
        if (r < clsr_pkg::MAX_ROWS && c < clsr_pkg::MAX_COLS) begin
          cur_r = clsr_pkg::ROW_W'(r);
          cur_c = clsr_pkg::COL_W'(c);
          step_words.push_back(mk_result(clsr_pkg::KIND_SET_ADDR, cell_addr(r, c),
                                         '0, '0, '0, 1'b0));
        end
      end
      clsr_pkg::OPC_REPORT: begin
        step_words.push_back(mk_result(clsr_pkg::KIND_CURSOR, '0, '0, cur_r, cur_c, 1'b0));
      end
      clsr_pkg::OPC_CLEAR: begin
        for (int i = 0; i < clsr_pkg::MAX_ROWS; i++) begin
          dirty_cols[i] = '0;
          for (int k = 0; k < clsr_pkg::MAX_COLS; k++)
            shadow_chars[i][k] = clsr_pkg::SPACE_CHAR;
        end
        step_words.push_back(mk_result(clsr_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0));
      end
      clsr_pkg::OPC_REFRESH: begin
        rows_eff = (rows_reg > clsr_pkg::MAX_ROWS) ? clsr_pkg::MAX_ROWS : rows_reg;
        cols_eff = (cols_reg > clsr_pkg::MAX_COLS) ? clsr_pkg::MAX_COLS : cols_reg;
        if (r < rows_eff) begin
          if (dirty_cols[r] != '0) begin
            for (int k = 0; k < cols_eff; k++) begin
              if (dirty_cols[r][k]) begin
                step_words.push_back(mk_result(clsr_pkg::KIND_WRITE_DATA, cell_addr(r, k),
                                               shadow_chars[r][k], '0, '0, 1'b0));
                rewrite_cursor = 1'b1;
              end
            end
            // bits above the active columns go too
            dirty_cols[r] = '0;
          end
          if (r == rows_eff - 1) begin
            if (rewrite_cursor)
              step_words.push_back(mk_result(clsr_pkg::KIND_SET_ADDR, cell_addr(cur_r, cur_c),
                                             '0, '0, '0, 1'b0));
            rewrite_cursor = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (step_words.size() > 0) begin
      tail      = step_words[step_words.size() - 1];
      tail.last = 1'b1;
      step_words[step_words.size() - 1] = tail;
    end
  endtask

  task automatic note_mismatch(input string what, input clsr_pkg::out_word_t want,
                               input clsr_pkg::out_word_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch at cycle %0d (%s): want kind %0d addr %0h data %0h row %0d col %0d",
               cycle_cnt, what, want.cmd_kind, want.address, want.data, want.pos_row,
               want.pos_col);
      $display("  want last %0b, got kind %0d addr %0h data %0h row %0d col %0d last %0b",
               want.last, got.cmd_kind, got.address, got.data, got.pos_row, got.pos_col,
               got.last);
    end
  endtask

  always @(posedge clk) begin
    clsr_pkg::out_word_t want;
    if (!rst && strobe === 1'b1) begin
      if (lcd_cmds_due.size() == 0) begin
        note_mismatch("word with nothing expected", '0, result);
      end else begin
        want = lcd_cmds_due.pop_front();
        if (want.cmd_kind !== result.cmd_kind || want.address !== result.address ||
            want.data !== result.data || want.pos_row !== result.pos_row ||
            want.pos_col !== result.pos_col || want.last !== result.last)
          note_mismatch("field differs", want, result);
      end
    end
  end

  function automatic clsr_pkg::in_word_t random_word();
    int         pick;
    logic [2:0] op;
    logic [2:0] r;
    logic [4:0] c;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 45)      op = clsr_pkg::OPC_WRITE_CHAR;
    else if (pick < 68) op = clsr_pkg::OPC_REFRESH;
    else if (pick < 80) op = clsr_pkg::OPC_SET_CURSOR;
    else if (pick < 89) op = clsr_pkg::OPC_REPORT;
    else if (pick < 93) op = clsr_pkg::OPC_CLEAR;
    else begin
      pick = $urandom_range(2);
      op = (pick == 0) ? OPC_RSVD5 : (pick == 1) ? OPC_RSVD6 : OPC_RSVD7;
    end
    r = ($urandom_range(7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
    c = ($urandom_range(9) == 0) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(19));
    // a small alphabet so that equal-byte writes happen often
    pick = $urandom_range(3);
    ch = (pick == 0) ? clsr_pkg::SPACE_CHAR : (pick == 1) ? 8'(8'h41 + $urandom_range(1)) :
         8'($urandom);
    return mk_word(op, r, c, ch);
  endfunction

  // burst pacing of the host side
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 4);
      start <= 1'b0;
      cmd   <= random_word();
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic issue_word(input clsr_pkg::in_word_t w, input bit typed, input int n_want,
                            input clsr_pkg::out_word_t want);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_lcd_cmds(w);
    if (typed) begin
      for (int i = 0; i < n_want; i++) lcd_cmds_due.push_back(want);
    end else begin
      foreach (step_words[i]) lcd_cmds_due.push_back(step_words[i]);
    end
  endtask

  task automatic settle();
    while (lcd_cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [clsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [clsr_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      clsr_pkg::REG_ACTIVE_ROWS: rows_reg    = val[2:0];
      clsr_pkg::REG_ACTIVE_COLS: cols_reg    = val[4:0];
      clsr_pkg::REG_ROW0_OFFSET: row_base[0] = val[clsr_pkg::ADDR_W-1:0];
      clsr_pkg::REG_ROW1_OFFSET: row_base[1] = val[clsr_pkg::ADDR_W-1:0];
      clsr_pkg::REG_ROW2_OFFSET: row_base[2] = val[clsr_pkg::ADDR_W-1:0];
      clsr_pkg::REG_ROW3_OFFSET: row_base[3] = val[clsr_pkg::ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int rows, input int cols, input int o0, input int o1,
                              input int o2, input int o3);
    write_reg(clsr_pkg::REG_ACTIVE_ROWS, clsr_pkg::CFG_W'(rows));
    write_reg(clsr_pkg::REG_ACTIVE_COLS, clsr_pkg::CFG_W'(cols));
    write_reg(clsr_pkg::REG_ROW0_OFFSET, clsr_pkg::CFG_W'(o0));
    write_reg(clsr_pkg::REG_ROW1_OFFSET, clsr_pkg::CFG_W'(o1));
    write_reg(clsr_pkg::REG_ROW2_OFFSET, clsr_pkg::CFG_W'(o2));
    write_reg(clsr_pkg::REG_ROW3_OFFSET, clsr_pkg::CFG_W'(o3));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int rows_eff;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        // full refresh: every active row in order
        rows_eff = (rows_reg > clsr_pkg::MAX_ROWS) ? clsr_pkg::MAX_ROWS : rows_reg;
        for (int r = 0; r < rows_eff; r++) begin
          pace();
          issue_word(mk_word(clsr_pkg::OPC_REFRESH, 3'(r), 5'($urandom), 8'($urandom)),
                     1'b0, 0, '0);
          sent++;
        end
        if (rows_eff == 0) sent++;
      end else begin
        pace();
        issue_word(random_word(), 1'b0, 0, '0);
        sent++;
      end
    end
  endtask

  task automatic add_row(input clsr_pkg::in_word_t w, input bit typed, input int n_want,
                         input clsr_pkg::out_word_t want);
    directed_row_t d;
    d.word   = w;
    d.typed  = typed;
    d.n_want = n_want;
    d.want   = want;
    directed_rows.push_back(d);
  endtask

  initial begin
    burst_left = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= clsr_pkg::REG_ACTIVE_ROWS;
    cfg_data  <= '0;
    lcd_reset_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values; unused fields of report and clear carry out-of-range or all-one values
    add_row(mk_word(clsr_pkg::OPC_REPORT, 3'd5, 5'd31, 8'hFF), 1'b1, 1,
            mk_result(clsr_pkg::KIND_CURSOR, '0, '0, 2'd0, 5'd0, 1'b1));
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd0, 5'd0, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd3, 5'd0, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd0, 5'd0, clsr_pkg::SPACE_CHAR), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd0, 5'd0, 8'hFF), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd3, 5'd19, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd4, 5'd0, 8'h41), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd7, 5'd31, 8'hFF), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd1, 5'd20, 8'h42), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_SET_CURSOR, 3'd3, 5'd19, 8'h00), 1'b1, 1,
            mk_result(clsr_pkg::KIND_SET_ADDR, 7'h67, '0, '0, '0, 1'b1));
    add_row(mk_word(clsr_pkg::OPC_SET_CURSOR, 3'd4, 5'd5, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_SET_CURSOR, 3'd2, 5'd25, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REPORT, 3'd0, 5'd0, 8'h00), 1'b1, 1,
            mk_result(clsr_pkg::KIND_CURSOR, '0, '0, 2'd3, 5'd19, 1'b1));
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd0, 5'd0, 8'h00), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd4, 5'd0, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd7, 5'd31, 8'hFF), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd3, 5'd0, 8'h00), 1'b0, 0, '0);
    add_row(mk_word(OPC_RSVD5, 3'd7, 5'd31, 8'hFF), 1'b1, 0, '0);
    add_row(mk_word(OPC_RSVD6, 3'd0, 5'd0, 8'h00), 1'b1, 0, '0);
    add_row(mk_word(OPC_RSVD7, 3'd2, 5'd3, 8'h41), 1'b1, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd2, 5'd5, 8'h78), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_CLEAR, 3'd7, 5'd31, 8'hFF), 1'b1, 1,
            mk_result(clsr_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b1));
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd2, 5'd0, 8'h00), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd1, 5'd19, 8'h55), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_WRITE_CHAR, 3'd1, 5'd0, 8'hAA), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd1, 5'd0, 8'h00), 1'b0, 0, '0);
    add_row(mk_word(clsr_pkg::OPC_REFRESH, 3'd3, 5'd0, 8'h00), 1'b0, 0, '0);

    foreach (directed_rows[i]) begin
      pace();
      issue_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].n_want,
                 directed_rows[i].want);
    end
    start <= 1'b0;
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_setting(1, 1, 0, 0, 0, 0);
        1: load_setting(clsr_pkg::MAX_ROWS, clsr_pkg::MAX_COLS, 127, 127, 127, 127);
        // nothing scanned, dirty bits pile up for the next setting
        2: load_setting(0, 0, $urandom_range(127), $urandom_range(127),
                        $urandom_range(127), $urandom_range(127));
        // above the limits, taken as the full display
        3: load_setting(7, 31, $urandom_range(127), $urandom_range(127),
                        $urandom_range(127), $urandom_range(127));
        4: load_setting(3, 12, $urandom_range(100, 127), $urandom_range(127),
                        $urandom_range(127), $urandom_range(127));
        default: load_setting($urandom_range(1, clsr_pkg::MAX_ROWS),
                              $urandom_range(1, clsr_pkg::MAX_COLS),
                              $urandom_range(127), $urandom_range(127),
                              $urandom_range(127), $urandom_range(127));
      endcase
      run_random(PHASE_ITEMS);
      start <= 1'b0;
      settle();
    end

    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_ram.sv
hw/rtl/clsr_queue.sv
hw/rtl/clsr_front.sv
hw/rtl/clsr_back.sv
hw/rtl/char_lcd_shadow_refresh_core.sv
tb/sv/tb_top.sv
